@@ sv/mcpt_pkg.sv @@
// Package for the multi-channel periodic timer: payload structs, opcodes,
// the token that travels along the channel chain, and default sizes.
// No dependencies.
`default_nettype none

package mcpt_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int MASK_WIDTH   = 16;
   localparam logic [15:0] SCAN_INTERVAL_RESET = 16'd10;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_CREATE = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_RELOAD = 3'd3;
   localparam logic [2:0] OP_SETPER = 3'd4;

   localparam logic [2:0] REG_SCAN_INTERVAL = 3'd0;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  channel;
      logic [31:0] period;
   } req_type;

   typedef struct packed {
      logic [MASK_WIDTH-1:0] fired_mask;
      logic                  found;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [2:0]            opcode;
      logic [3:0]            channel;
      logic [31:0]           period;
      logic [31:0]           now;
      logic                  scan;
      logic [MASK_WIDTH-1:0] mask;
      logic                  found;
   } token_type;

endpackage

`default_nettype wire

@@ sv/multi_channel_periodic_timer_core.sv @@
// Top level of the multi-channel periodic timer: tick counter, scan decision,
// configuration port, channel cell chain and result buffer.
// Depends on mcpt_pkg and mcpt_cell.
//
// Usage:
//   req channel: one transaction per operation (tick, create, delete,
//   reload, set period). req_stall is high while a transaction is in flight
//   or a second finished result is parked behind a stalled output.
//   rsp channel: exactly one result per request, in request order.
//   A request is latched, injected as a token into cell 0 on the next
//   cycle and walks one cell per cycle down the NUM_CHANNELS-cell chain;
//   each cell checks and updates its own channel as the token passes.
//   The result passes the request latch, the injection register, each cell
//   register and the result register before rsp_valid rises. A new request
//   is accepted only after the previous token has left the chain and
//   req_stall has dropped.
//   When the receiver stalls, one further finished result is held in a
//   skid register; after that req_stall stays high until rsp drains.
//   Reset (synchronous, active high) clears the tick count, the scan point,
//   all channel active flags and the buffers; scan_interval returns to 10.
//   Configuration: APB-style write of scan_interval at byte address 0.
`default_nettype none

module multi_channel_periodic_timer_core #(
   parameter int NUM_CHANNELS = mcpt_pkg::NUM_CHANNELS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mcpt_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mcpt_pkg::rsp_type      rsp_payload,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [15:0]         scan_interval_ff;
   logic [31:0]         tick_count_ff;
   logic [31:0]         last_scan_ff;
   logic                busy_ff;
   logic                pend_ff;
   mcpt_pkg::req_type   req_ff;
   mcpt_pkg::token_type inj_ff, inj_in;
   logic                rsp_valid_ff, hold_valid_ff;
   mcpt_pkg::rsp_type   rsp_ff, hold_ff, exit_rsp;

   mcpt_pkg::token_type chain [NUM_CHANNELS+1];

   logic        req_take;
   logic        rsp_take;
   logic        exit_valid;
   logic        csr_write;
   logic [31:0] since_scan;
   logic        do_scan;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == mcpt_pkg::REG_SCAN_INTERVAL[0]);
   assign prdata    = (paddr[2] == mcpt_pkg::REG_SCAN_INTERVAL[0]) ?
                      {16'b0, scan_interval_ff} : 32'b0;

   assign req_stall = busy_ff | hold_valid_ff;
   assign req_take  = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rsp_take  = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      since_scan = tick_count_ff - last_scan_ff;
      do_scan = (req_ff.opcode == mcpt_pkg::OP_TICK) && (since_scan > {16'b0, scan_interval_ff});
      inj_in.valid   = pend_ff;
      inj_in.opcode  = req_ff.opcode;
      inj_in.channel = req_ff.channel;
      inj_in.period  = req_ff.period;
      inj_in.now     = tick_count_ff;
      inj_in.scan    = do_scan;
      inj_in.mask    = '0;
      inj_in.found   = 1'b0;
   end

   assign chain[0] = inj_ff;

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
      mcpt_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .token_in (chain[i]),
         .token_out(chain[i+1])
      );
   end

   assign exit_valid          = chain[NUM_CHANNELS].valid;
   assign exit_rsp.fired_mask = chain[NUM_CHANNELS].mask;
   assign exit_rsp.found      = chain[NUM_CHANNELS].found;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_interval_ff <= mcpt_pkg::SCAN_INTERVAL_RESET;
         tick_count_ff    <= 32'd0;
         last_scan_ff     <= 32'd0;
         busy_ff          <= 1'b0;
         pend_ff          <= 1'b0;
         inj_ff.valid     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         hold_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            scan_interval_ff <= pwdata[15:0];
         end
         if (req_take) begin
            busy_ff <= 1'b1;
            if (req_payload.opcode == mcpt_pkg::OP_TICK) begin
               tick_count_ff <= tick_count_ff + 32'd1;
            end
         end else if (exit_valid) begin
            busy_ff <= 1'b0;
         end
         pend_ff      <= req_take;
         inj_ff.valid <= inj_in.valid;
         if (pend_ff && do_scan) begin
            last_scan_ff <= tick_count_ff;
         end
         if (exit_valid) begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               hold_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            if (hold_valid_ff) begin
               hold_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end

      if (req_take) begin
         req_ff <= req_payload;
      end
      inj_ff.opcode  <= inj_in.opcode;
      inj_ff.channel <= inj_in.channel;
      inj_ff.period  <= inj_in.period;
      inj_ff.now     <= inj_in.now;
      inj_ff.scan    <= inj_in.scan;
      inj_ff.mask    <= inj_in.mask;
      inj_ff.found   <= inj_in.found;
      if (exit_valid) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_ff <= exit_rsp;
         end else begin
            hold_ff <= exit_rsp;
         end
      end else if (rsp_take && hold_valid_ff) begin
         rsp_ff <= hold_ff;
      end
   end

endmodule

`default_nettype wire

@@ sv/mcpt_cell.sv @@
// One timer channel of the chain: holds active flag, start and period,
// and updates the passing transaction token. Depends on mcpt_pkg.
`default_nettype none

module mcpt_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mcpt_pkg::token_type token_in,
   output mcpt_pkg::token_type      token_out
);

   localparam logic HAS_BIT = (CELL_INDEX < mcpt_pkg::MASK_WIDTH);
   localparam int   MASK_BIT = (CELL_INDEX < mcpt_pkg::MASK_WIDTH) ? CELL_INDEX : 0;

   logic                active_ff, active_in;
   logic [31:0]         start_ff, start_in;
   logic [31:0]         period_ff, period_in;
   mcpt_pkg::token_type token_ff, token_in_next;

   logic        match;
   logic        fire;
   logic [31:0] elapsed;

   always_comb begin
      elapsed = token_in.now - start_ff;
      fire = token_in.valid && token_in.scan && active_ff && (elapsed > period_ff);
      match = token_in.valid && (32'(token_in.channel) == CELL_INDEX) &&
              ((token_in.opcode == mcpt_pkg::OP_CREATE) ||
               (token_in.opcode == mcpt_pkg::OP_DELETE) ||
               (token_in.opcode == mcpt_pkg::OP_RELOAD) ||
               (token_in.opcode == mcpt_pkg::OP_SETPER));

      active_in = active_ff;
      start_in  = start_ff;
      period_in = period_ff;
      token_in_next = token_in;

      if (fire) begin
         start_in = token_in.now;
         if (HAS_BIT) begin
            token_in_next.mask = token_in.mask | (mcpt_pkg::MASK_WIDTH'(1) << MASK_BIT);
         end
      end

      if (match) begin
         token_in_next.found = active_ff;
         case (token_in.opcode)
            mcpt_pkg::OP_CREATE: begin
               active_in = 1'b1;
               period_in = token_in.period;
               start_in  = token_in.now;
            end
            mcpt_pkg::OP_DELETE: begin
               active_in = 1'b0;
            end
            mcpt_pkg::OP_RELOAD: begin
               if (active_ff) begin
                  start_in = token_in.now;
               end
            end
            mcpt_pkg::OP_SETPER: begin
               if (active_ff) begin
                  period_in = token_in.period;
                  start_in  = token_in.now;
               end
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         token_ff.valid <= 1'b0;
      end else begin
         active_ff      <= active_in;
         token_ff.valid <= token_in_next.valid;
      end
      start_ff          <= start_in;
      period_ff         <= period_in;
      token_ff.opcode   <= token_in_next.opcode;
      token_ff.channel  <= token_in_next.channel;
      token_ff.period   <= token_in_next.period;
      token_ff.now      <= token_in_next.now;
      token_ff.scan     <= token_in_next.scan;
      token_ff.mask     <= token_in_next.mask;
      token_ff.found    <= token_in_next.found;
   end

   assign token_out = token_ff;

endmodule

`default_nettype wire
